// ===== design/atlm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package atlm_pkg;

   localparam int WINDOW = 10;
   localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W = 17 + $clog2(WINDOW + 1);

   localparam int CFG_W = 15;
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNIFICANCE_THRESHOLD = 2'd1;
   localparam logic [CFG_W-1:0] LEVEL_THRESHOLD_RESET = 15'd640;
   localparam logic [CFG_W-1:0] SIGNIFICANCE_THRESHOLD_RESET = 15'd256;

   localparam logic [1:0] CLASS_LEVEL = 2'd0;
   localparam logic [1:0] CLASS_TILT_X = 2'd1;
   localparam logic [1:0] CLASS_TILT_Y = 2'd2;
   localparam logic [1:0] CLASS_BOUNDARY = 2'd3;

   localparam int CORDIC_W = 28;
   localparam int Z_W = 22;
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W = 4;
   localparam logic signed [Z_W-1:0] Z_QUARTER = 22'sd368640;

   localparam int SQRT_STEPS = 24;
   localparam int SQRT_CNT_W = 5;

   // division by a constant: quotient = (n * ceil(2^RECIP_SHIFT / d)) >> RECIP_SHIFT,
   // exact for every dividend below 2^31 + 2^30
   localparam int DIV_W = 32;
   localparam int RECIP_SHIFT = 35;
   localparam int RECIP_W = 36;
   localparam logic [RECIP_W-1:0] AVG_RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
   localparam logic [RECIP_W-1:0] GYRO_RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd124) / 64'd125);

   typedef struct packed {
      logic busy;
   } unit_status_type;

   function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
      logic signed [Z_W-1:0] v;
      case (i)
         4'd0: v = 22'sd184320;
         4'd1: v = 22'sd108810;
         4'd2: v = 22'sd57492;
         4'd3: v = 22'sd29184;
         4'd4: v = 22'sd14649;
         4'd5: v = 22'sd7331;
         4'd6: v = 22'sd3667;
         4'd7: v = 22'sd1833;
         4'd8: v = 22'sd917;
         4'd9: v = 22'sd458;
         4'd10: v = 22'sd229;
         4'd11: v = 22'sd115;
         4'd12: v = 22'sd57;
         4'd13: v = 22'sd29;
         4'd14: v = 22'sd14;
         4'd15: v = 22'sd7;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== design/atlm_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface atlm_req_if;
   logic valid;
   logic ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] rate_x;
   logic signed [15:0] rate_y;
   logic [15:0] elapsed_ms;

   modport source(output valid, accel_x, accel_y, accel_z, rate_x, rate_y, elapsed_ms,
                  input ready);
   modport sink(input valid, accel_x, accel_y, accel_z, rate_x, rate_y, elapsed_ms,
                output ready);
endinterface

`default_nettype wire

// ===== design/atlm_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface atlm_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] roll_angle;
   logic signed [15:0] pitch_angle;
   logic [1:0] level_class;

   modport source(output valid, roll_angle, pitch_angle, level_class, input ready);
   modport sink(input valid, roll_angle, pitch_angle, level_class, output ready);
endinterface

`default_nettype wire

// ===== design/accel_tilt_level_monitor.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Each request runs a 24-step square root with the roll CORDIC alongside, a 16-step pitch
// CORDIC, four reciprocal divisions and decide; a new request is taken only in idle, after
// the last one has left decide. A new report that meets a result still held on rsp waits in
// the decide state, and req stays not ready until rsp takes the old one.
// Reset (synchronous, active high) clears rings, running sums, ring position,
// last reported angles and loads both thresholds with their defaults at once.
module accel_tilt_level_monitor (
   input  wire logic                                clock,
   input  wire logic                                reset,
   atlm_req_if.sink                                 req,
   atlm_rsp_if.source                               rsp,
   input  wire logic                                csr_we,
   input  wire logic [atlm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [atlm_pkg::CFG_W-1:0]          csr_wdata
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_ROLL   = 8'b0000_0010,
      ST_PITCH  = 8'b0000_0100,
      ST_RAVG   = 8'b0000_1000,
      ST_PAVG   = 8'b0001_0000,
      ST_RGYR   = 8'b0010_0000,
      ST_PGYR   = 8'b0100_0000,
      ST_DECIDE = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic signed [15:0] ax_ff, rx_ff, ry_ff;
   logic [15:0] ms_ff;
   logic signed [15:0] roll_ff, roll_in, pitch_ff, pitch_in;
   logic signed [15:0] ravg_ff, ravg_in, pavg_ff, pavg_in;
   logic signed [25:0] rgyr_ff, rgyr_in, pgyr_ff, pgyr_in;
   logic signed [15:0] roll_ring_ff [atlm_pkg::WINDOW];
   logic signed [15:0] pitch_ring_ff [atlm_pkg::WINDOW];
   logic signed [atlm_pkg::SUM_W-1:0] rsum_ff, psum_ff;
   logic [atlm_pkg::POS_W-1:0] pos_ff;
   logic signed [15:0] last_roll_ff, last_pitch_ff;
   logic [atlm_pkg::CFG_W-1:0] level_ff, sig_ff;
   logic div_go_ff, div_go_in;
   logic rsp_valid_ff;
   logic signed [15:0] rsp_roll_ff, rsp_pitch_ff;
   logic [1:0] rsp_class_ff;

   logic cordic_start, sqrt_start, div_start;
   logic signed [atlm_pkg::CORDIC_W-1:0] cordic_y, cordic_x;
   logic signed [15:0] cordic_angle;
   logic [23:0] sqrt_root;
   logic [atlm_pkg::DIV_W-1:0] div_num, div_q;
   logic [atlm_pkg::RECIP_W-1:0] div_recip;
   atlm_pkg::unit_status_type cordic_st, sqrt_st, div_st;

   logic accept, ring_write, report, load_rsp;
   logic [atlm_pkg::SUM_W-1:0] rsum_mag, psum_mag;
   logic [15:0] rx_mag, ry_mag;
   logic signed [15:0] roll_out, pitch_out;
   logic signed [16:0] roll_diff, pitch_diff;
   logic [16:0] roll_dabs, pitch_dabs, roll_abs, pitch_abs;
   logic [1:0] level_class;

   function automatic logic signed [15:0] sat16(input logic signed [26:0] v);
      logic signed [15:0] r;
      if (v > 27'sd32767) begin
         r = 16'sd32767;
      end else if (v < -27'sd32768) begin
         r = -16'sd32768;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic [16:0] abs17(input logic signed [16:0] v);
      return v[16] ? 17'(-v) : 17'(v);
   endfunction

   atlm_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .y_in  (cordic_y),
      .x_in  (cordic_x),
      .angle (cordic_angle),
      .status(cordic_st)
   );

   atlm_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .a_in  (req.accel_y),
      .b_in  (req.accel_z),
      .root  (sqrt_root),
      .status(sqrt_st)
   );

   atlm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_num),
      .recip   (div_recip),
      .quotient(div_q),
      .status  (div_st)
   );

   assign req.ready = (state_ff == ST_IDLE);
   assign accept = req.valid && req.ready;
   assign sqrt_start = accept;

   assign rsum_mag = rsum_ff[atlm_pkg::SUM_W-1] ? atlm_pkg::SUM_W'(-rsum_ff) : rsum_ff;
   assign psum_mag = psum_ff[atlm_pkg::SUM_W-1] ? atlm_pkg::SUM_W'(-psum_ff) : psum_ff;
   assign rx_mag = rx_ff[15] ? 16'(-rx_ff) : rx_ff;
   assign ry_mag = ry_ff[15] ? 16'(-ry_ff) : ry_ff;

   assign roll_out = sat16(27'(ravg_ff) + 27'(rgyr_ff));
   assign pitch_out = sat16(27'(pavg_ff) + 27'(pgyr_ff));
   assign roll_diff = 17'(roll_out) - 17'(last_roll_ff);
   assign pitch_diff = 17'(pitch_out) - 17'(last_pitch_ff);
   assign roll_dabs = abs17(roll_diff);
   assign pitch_dabs = abs17(pitch_diff);
   assign report = (roll_dabs > {2'b00, sig_ff}) || (pitch_dabs > {2'b00, sig_ff});
   assign roll_abs = abs17(17'(roll_out));
   assign pitch_abs = abs17(17'(pitch_out));

   always_comb begin
      if (roll_abs < {2'b00, level_ff} && pitch_abs < {2'b00, level_ff}) begin
         level_class = atlm_pkg::CLASS_LEVEL;
      end else if (roll_abs > {2'b00, level_ff}) begin
         level_class = atlm_pkg::CLASS_TILT_X;
      end else if (pitch_abs > {2'b00, level_ff}) begin
         level_class = atlm_pkg::CLASS_TILT_Y;
      end else begin
         level_class = atlm_pkg::CLASS_BOUNDARY;
      end
   end

   always_comb begin
      state_in = state_ff;
      cordic_start = 1'b0;
      cordic_y = {{4{req.accel_y[15]}}, req.accel_y, 8'b0};
      cordic_x = {{4{req.accel_z[15]}}, req.accel_z, 8'b0};
      div_start = 1'b0;
      div_go_in = div_go_ff;
      div_num = '0;
      div_recip = atlm_pkg::AVG_RECIP;
      roll_in = roll_ff;
      pitch_in = pitch_ff;
      ravg_in = ravg_ff;
      pavg_in = pavg_ff;
      rgyr_in = rgyr_ff;
      pgyr_in = pgyr_ff;
      ring_write = 1'b0;
      load_rsp = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cordic_start = 1'b1;
               state_in = ST_ROLL;
            end
         end
         ST_ROLL: begin
            cordic_y = -{{4{ax_ff[15]}}, ax_ff, 8'b0};
            cordic_x = {4'b0, sqrt_root};
            if (!cordic_st.busy && !sqrt_st.busy) begin
               roll_in = cordic_angle;
               cordic_start = 1'b1;
               state_in = ST_PITCH;
            end
         end
         ST_PITCH: begin
            if (!cordic_st.busy) begin
               pitch_in = cordic_angle;
               ring_write = 1'b1;
               state_in = ST_RAVG;
            end
         end
         ST_RAVG, ST_PAVG, ST_RGYR, ST_PGYR: begin
            case (state_ff)
               ST_RAVG: div_num = atlm_pkg::DIV_W'(rsum_mag) +
                                  atlm_pkg::DIV_W'(atlm_pkg::WINDOW / 2);
               ST_PAVG: div_num = atlm_pkg::DIV_W'(psum_mag) +
                                  atlm_pkg::DIV_W'(atlm_pkg::WINDOW / 2);
               ST_RGYR: div_num = rx_mag * ms_ff + atlm_pkg::DIV_W'(62);
               default: div_num = ry_mag * ms_ff + atlm_pkg::DIV_W'(62);
            endcase
            if (state_ff inside {ST_RGYR, ST_PGYR}) begin
               div_recip = atlm_pkg::GYRO_RECIP;
            end
            if (!div_go_ff) begin
               div_start = 1'b1;
               div_go_in = 1'b1;
            end else if (!div_st.busy) begin
               div_go_in = 1'b0;
               case (state_ff)
                  ST_RAVG: begin
                     ravg_in = rsum_ff[atlm_pkg::SUM_W-1] ? 16'(-div_q[15:0]) : div_q[15:0];
                     state_in = ST_PAVG;
                  end
                  ST_PAVG: begin
                     pavg_in = psum_ff[atlm_pkg::SUM_W-1] ? 16'(-div_q[15:0]) : div_q[15:0];
                     state_in = ST_RGYR;
                  end
                  ST_RGYR: begin
                     rgyr_in = rx_ff[15] ? 26'(-div_q[25:0]) : div_q[25:0];
                     state_in = ST_PGYR;
                  end
                  default: begin
                     pgyr_in = ry_ff[15] ? 26'(-div_q[25:0]) : div_q[25:0];
                     state_in = ST_DECIDE;
                  end
               endcase
            end
         end
         ST_DECIDE: begin
            if (!report) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         div_go_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsum_ff <= '0;
         psum_ff <= '0;
         pos_ff <= '0;
         last_roll_ff <= '0;
         last_pitch_ff <= '0;
         level_ff <= atlm_pkg::LEVEL_THRESHOLD_RESET;
         sig_ff <= atlm_pkg::SIGNIFICANCE_THRESHOLD_RESET;
         for (int i = 0; i < atlm_pkg::WINDOW; i++) begin
            roll_ring_ff[i] <= '0;
            pitch_ring_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         div_go_ff <= div_go_in;
         if (csr_we) begin
            case (csr_index)
               atlm_pkg::CSR_LEVEL_THRESHOLD: level_ff <= csr_wdata;
               atlm_pkg::CSR_SIGNIFICANCE_THRESHOLD: sig_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (ring_write) begin
            roll_ring_ff[pos_ff] <= roll_ff;
            pitch_ring_ff[pos_ff] <= pitch_in;
            rsum_ff <= rsum_ff + atlm_pkg::SUM_W'(roll_ff) -
                       atlm_pkg::SUM_W'(roll_ring_ff[pos_ff]);
            psum_ff <= psum_ff + atlm_pkg::SUM_W'(pitch_in) -
                       atlm_pkg::SUM_W'(pitch_ring_ff[pos_ff]);
            pos_ff <= (pos_ff == atlm_pkg::POS_W'(atlm_pkg::WINDOW - 1)) ? '0 : pos_ff + 1'b1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
            last_roll_ff <= roll_out;
            last_pitch_ff <= pitch_out;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         ax_ff <= req.accel_x;
         rx_ff <= req.rate_x;
         ry_ff <= req.rate_y;
         ms_ff <= req.elapsed_ms;
      end
      if (load_rsp) begin
         rsp_roll_ff <= roll_out;
         rsp_pitch_ff <= pitch_out;
         rsp_class_ff <= level_class;
      end
      roll_ff <= roll_in;
      pitch_ff <= pitch_in;
      ravg_ff <= ravg_in;
      pavg_ff <= pavg_in;
      rgyr_ff <= rgyr_in;
      pgyr_ff <= pgyr_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.roll_angle = rsp_roll_ff;
   assign rsp.pitch_angle = rsp_pitch_ff;
   assign rsp.level_class = rsp_class_ff;

`ifndef SYNTHESIS
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= atlm_pkg::POS_W'(atlm_pkg::WINDOW - 1))
      else $error("ring position out of range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req.ready)
      else $error("request taken while busy");

   a_cordic_owner: assert property (@(posedge clock) disable iff (reset)
      cordic_st.busy |-> (state_ff == ST_ROLL || state_ff == ST_PITCH))
      else $error("cordic running outside angle states");

   a_last_matches: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (last_roll_ff == rsp.roll_angle && last_pitch_ff == rsp.pitch_angle))
      else $error("last reported pair differs from result");
`endif

endmodule

`default_nettype wire

// ===== design/atlm_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none

module atlm_cordic (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   input  wire logic signed [atlm_pkg::CORDIC_W-1:0]   y_in,
   input  wire logic signed [atlm_pkg::CORDIC_W-1:0]   x_in,
   output logic signed [15:0]                          angle,
   output atlm_pkg::unit_status_type                   status
);

   logic signed [atlm_pkg::CORDIC_W-1:0] x_ff, x_in_w, y_ff, y_in_w, dx, dy;
   logic signed [atlm_pkg::Z_W-1:0] z_ff, z_in, z_round;
   logic [atlm_pkg::STEP_W-1:0] step_ff, step_in;
   logic busy_ff, busy_in, zero_ff, zero_in;

   always_comb begin
      x_in_w = x_ff;
      y_in_w = y_ff;
      z_in = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      zero_in = zero_ff;
      dx = x_ff >>> step_ff;
      dy = y_ff >>> step_ff;
      if (start) begin
         zero_in = (x_in == '0) && (y_in == '0);
         busy_in = 1'b1;
         step_in = '0;
         if (x_in < 0) begin
            if (y_in >= 0) begin
               x_in_w = y_in;
               y_in_w = -x_in;
               z_in = atlm_pkg::Z_QUARTER;
            end else begin
               x_in_w = -y_in;
               y_in_w = x_in;
               z_in = -atlm_pkg::Z_QUARTER;
            end
         end else begin
            x_in_w = x_in;
            y_in_w = y_in;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in_w = x_ff + dy;
            y_in_w = y_ff - dx;
            z_in = z_ff + atlm_pkg::atan_entry(step_ff);
         end else begin
            x_in_w = x_ff - dy;
            y_in_w = y_ff + dx;
            z_in = z_ff - atlm_pkg::atan_entry(step_ff);
         end
         step_in = step_ff + 1'b1;
         if (step_ff == atlm_pkg::STEP_W'(atlm_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      x_ff <= x_in_w;
      y_ff <= y_in_w;
      z_ff <= z_in;
      zero_ff <= zero_in;
   end

   assign z_round = (z_ff + atlm_pkg::Z_W'(16)) >>> 5;
   assign angle = zero_ff ? 16'sd0 : z_round[15:0];
   assign status.busy = busy_ff;

endmodule

`default_nettype wire

// ===== design/atlm_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

module atlm_isqrt (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic signed [15:0]     a_in,
   input  wire logic signed [15:0]     b_in,
   output logic [23:0]                 root,
   output atlm_pkg::unit_status_type   status
);

   logic [31:0] n_ff, n_in;
   logic [27:0] rem_ff, rem_in, rem_try;
   logic [25:0] trial;
   logic [23:0] root_ff, root_in;
   logic [atlm_pkg::SQRT_CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic signed [31:0] sq_a, sq_b;

   always_comb begin
      sq_a = a_in * a_in;
      sq_b = b_in * b_in;
      n_in = n_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      rem_try = {rem_ff[25:0], n_ff[31:30]};
      trial = {root_ff, 2'b01};
      if (start) begin
         n_in = $unsigned(sq_a) + $unsigned(sq_b);
         rem_in = '0;
         root_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in = {n_ff[29:0], 2'b00};
         if (rem_try >= {2'b00, trial}) begin
            rem_in = rem_try - {2'b00, trial};
            root_in = {root_ff[22:0], 1'b1};
         end else begin
            rem_in = rem_try;
            root_in = {root_ff[22:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == atlm_pkg::SQRT_CNT_W'(atlm_pkg::SQRT_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      n_ff <= n_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;
   assign status.busy = busy_ff;

endmodule

`default_nettype wire

// ===== design/atlm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module atlm_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [atlm_pkg::DIV_W-1:0]      dividend,
   input  wire logic [atlm_pkg::RECIP_W-1:0]    recip,
   output logic [atlm_pkg::DIV_W-1:0]           quotient,
   output atlm_pkg::unit_status_type            status
);

   logic [atlm_pkg::DIV_W-1:0] n_ff, n_in, q_ff, q_in;
   logic [atlm_pkg::RECIP_W-1:0] m_ff, m_in;
   logic [atlm_pkg::DIV_W+atlm_pkg::RECIP_W-1:0] prod;
   logic busy_ff, busy_in;

   always_comb begin
      n_in = n_ff;
      m_in = m_ff;
      q_in = q_ff;
      busy_in = busy_ff;
      prod = (atlm_pkg::DIV_W + atlm_pkg::RECIP_W)'(n_ff) *
             (atlm_pkg::DIV_W + atlm_pkg::RECIP_W)'(m_ff);
      if (start) begin
         n_in = dividend;
         m_in = recip;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in = prod[atlm_pkg::RECIP_SHIFT +: atlm_pkg::DIV_W];
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      n_ff <= n_in;
      m_ff <= m_in;
      q_ff <= q_in;
   end

   assign quotient = q_ff;
   assign status.busy = busy_ff;

endmodule

`default_nettype wire

// ===== tb/sv/tb_accel_tilt_level_monitor.sv =====
`timescale 1ns / 1ps

module tb_accel_tilt_level_monitor;

   localparam int SETTLE_CYCLES = 400;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam logic [atlm_pkg::CSR_IDX_W-1:0] CSR_SPARE_LOW = 2'd2;
   localparam logic [atlm_pkg::CSR_IDX_W-1:0] CSR_SPARE_HIGH = 2'd3;

   typedef struct {
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic signed [15:0] rx;
      logic signed [15:0] ry;
      logic [15:0] ms;
   } sample_type;

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
      logic [1:0] cls;
   } report_type;

   typedef struct {
      sample_type s;
      bit typed;
      bit has_report;
      report_type r;
   } tilt_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [atlm_pkg::CSR_IDX_W-1:0] csr_index;
   logic [atlm_pkg::CFG_W-1:0] csr_wdata;

   atlm_req_if req ();
   atlm_rsp_if rsp ();

   accel_tilt_level_monitor dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // tilt model state
   longint roll_hist[atlm_pkg::WINDOW];
   longint pitch_hist[atlm_pkg::WINDOW];
   int hist_pos;
   longint last_roll_rep, last_pitch_rep;
   longint level_lim, change_lim;

   const longint arc_step[16] = '{184320, 108810, 57492, 29184, 14649, 7331, 3667, 1833,
                                  917, 458, 229, 115, 57, 29, 14, 7};

   report_type pending_reports[$];
   int errors = 0;
   int reports_seen = 0;
   int requests_sent = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles = 0;
   longint cycles = 0;

   function automatic longint tilt_atan2(longint y, longint x);
      longint z, t, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 90 * 4096;
         end else begin
            t = x; x = -y; y = t; z = -90 * 4096;
         end
      end
      for (int i = 0; i < 16; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (y > 0) begin
            x += dy; y -= dx; z += arc_step[i];
         end else begin
            x -= dy; y += dx; z -= arc_step[i];
         end
      end
      return (z + 16) >>> 5;
   endfunction

   function automatic longint int_root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic longint round_div(longint n, longint d);
      return n >= 0 ? (n + d / 2) / d : -((-n + d / 2) / d);
   endfunction

   function automatic longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic bit predict_report(input sample_type s, output report_type r);
      longint ax, ay, az, roll, pitch, rsum, psum, ar, ap;
      ax = longint'(s.ax);
      ay = longint'(s.ay);
      az = longint'(s.az);
      roll = tilt_atan2(ay * 256, az * 256);
      pitch = tilt_atan2(-ax * 256, int_root(longint'(ay * ay + az * az) << 16));
      roll_hist[hist_pos] = roll;
      pitch_hist[hist_pos] = pitch;
      hist_pos = (hist_pos + 1) % atlm_pkg::WINDOW;
      rsum = 0;
      psum = 0;
      for (int i = 0; i < atlm_pkg::WINDOW; i++) begin
         rsum += roll_hist[i];
         psum += pitch_hist[i];
      end
      roll = clamp16(round_div(rsum, atlm_pkg::WINDOW) +
                     round_div(longint'(s.rx) * s.ms, 125));
      pitch = clamp16(round_div(psum, atlm_pkg::WINDOW) +
                      round_div(longint'(s.ry) * s.ms, 125));
      if (!(mag(roll - last_roll_rep) > change_lim || mag(pitch - last_pitch_rep) > change_lim))
         return 0;
      last_roll_rep = roll;
      last_pitch_rep = pitch;
      ar = mag(roll);
      ap = mag(pitch);
      r.roll = roll[15:0];
      r.pitch = pitch[15:0];
      if (ar < level_lim && ap < level_lim) r.cls = atlm_pkg::CLASS_LEVEL;
      else if (ar > level_lim) r.cls = atlm_pkg::CLASS_TILT_X;
      else if (ap > level_lim) r.cls = atlm_pkg::CLASS_TILT_Y;
      else r.cls = atlm_pkg::CLASS_BOUNDARY;
      return 1;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side
   initial begin
      report_type e;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp.valid && rsp.ready) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
               errors++;
               $display("%0t: expected no report, got roll=%0d pitch=%0d class=%0d", $time,
                        rsp.roll_angle, rsp.pitch_angle, rsp.level_class);
            end else begin
               e = pending_reports.pop_front();
               if (rsp.roll_angle !== e.roll || rsp.pitch_angle !== e.pitch ||
                   rsp.level_class !== e.cls) begin
                  errors++;
                  $display("%0t: expected roll=%0d pitch=%0d class=%0d, got %0d %0d %0d",
                           $time, e.roll, e.pitch, e.cls, rsp.roll_angle,
                           rsp.pitch_angle, rsp.level_class);
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic write_csr(input logic [atlm_pkg::CSR_IDX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[atlm_pkg::CFG_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == atlm_pkg::CSR_LEVEL_THRESHOLD) level_lim = value & 32'h7fff;
      else if (idx == atlm_pkg::CSR_SIGNIFICANCE_THRESHOLD) change_lim = value & 32'h7fff;
   endtask

   // returns after the request is taken; valid stays up for a back-to-back request
   task automatic send_request(input sample_type s, input bit typed, input bit has_rep,
                               input report_type typed_rep);
      report_type r;
      bit got;
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.accel_x <= s.ax;
      req.accel_y <= s.ay;
      req.accel_z <= s.az;
      req.rate_x <= s.rx;
      req.rate_y <= s.ry;
      req.elapsed_ms <= s.ms;
      do @(posedge clock); while (!req.ready);
      requests_sent++;
      got = predict_report(s, r);
      if (typed) begin
         if (got != has_rep || (got && r != typed_rep)) begin
            errors++;
            $display("%0t: model disagrees with typed row: expected %0d/%0d/%0d has=%0d",
                     $time, typed_rep.roll, typed_rep.pitch, typed_rep.cls, has_rep);
         end
         got = has_rep;
         r = typed_rep;
      end
      if (got) pending_reports.push_back(r);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_axis();
      case ($urandom_range(9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sd0;
         3, 4: return $signed(16'($urandom_range(400))) - 16'sd200;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      s.ax = pick_axis();
      s.ay = pick_axis();
      s.az = pick_axis();
      s.rx = 16'($urandom);
      s.ry = 16'($urandom);
      case ($urandom_range(9))
         0: s.ms = 16'($urandom);
         1: s.ms = 16'd0;
         default: s.ms = 16'($urandom_range(20));
      endcase
      return s;
   endfunction

   task automatic random_phase(input int count, input int idle, input int stall);
      report_type none;
      none = '{0, 0, 0};
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < count; i++)
         send_request(random_sample(), 0, 0, none);
      drain();
   endtask

   tilt_row_type rows[$];

   function automatic tilt_row_type mk(int ax, int ay, int az, int rx, int ry, int ms,
                                       bit typed = 0, bit has = 0, int roll = 0,
                                       int pitch = 0,
                                       logic [1:0] cls = atlm_pkg::CLASS_LEVEL);
      tilt_row_type t;
      t.s = '{16'(ax), 16'(ay), 16'(az), 16'(rx), 16'(ry), 16'(ms)};
      t.typed = typed;
      t.has_report = has;
      t.r = '{16'(roll), 16'(pitch), cls};
      return t;
   endfunction

   initial begin
      report_type none;
      none = '{0, 0, 0};
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req.valid <= 1'b0;
      req.accel_x <= '0;
      req.accel_y <= '0;
      req.accel_z <= '0;
      req.rate_x <= '0;
      req.rate_y <= '0;
      req.elapsed_ms <= '0;
      for (int i = 0; i < atlm_pkg::WINDOW; i++) begin
         roll_hist[i] = 0;
         pitch_hist[i] = 0;
      end
      hist_pos = 0;
      last_roll_rep = 0;
      last_pitch_rep = 0;
      level_lim = atlm_pkg::LEVEL_THRESHOLD_RESET;
      change_lim = atlm_pkg::SIGNIFICANCE_THRESHOLD_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      rows.push_back(mk(0, 0, 0, 0, 0, 0, 1, 0));
      rows.push_back(mk(0, 0, 0, 32767, 32767, 65535, 1, 1, 32767, 32767,
                        atlm_pkg::CLASS_TILT_X));
      rows.push_back(mk(0, 0, 0, -32768, -32768, 65535, 1, 1, -32768, -32768,
                        atlm_pkg::CLASS_TILT_X));
      rows.push_back(mk(0, 0, 0, 0, 0, 0, 1, 1, 0, 0, atlm_pkg::CLASS_LEVEL));
      rows.push_back(mk(0, 0, -100, 0, 0, 0));
      rows.push_back(mk(0, 0, -32768, 0, 0, 0));
      rows.push_back(mk(32767, 0, 0, 0, 0, 0));
      rows.push_back(mk(-32768, 0, 0, 0, 0, 0));
      rows.push_back(mk(0, 32767, 0, 0, 0, 0));
      rows.push_back(mk(0, -32768, 0, 0, 0, 0));
      rows.push_back(mk(0, 0, 32767, 0, 0, 0));
      rows.push_back(mk(-32768, -32768, -32768, 0, 0, 0));
      rows.push_back(mk(32767, 32767, 32767, 0, 0, 0));
      rows.push_back(mk(-32768, -1, -32768, 0, 0, 0));
      rows.push_back(mk(100, 100, 100, 125, -125, 1));
      rows.push_back(mk(0, 16384, 16384, 0, 0, 0));
      rows.push_back(mk(0, 0, 1000, 1000, -1000, 1));
      rows.push_back(mk(-500, 300, -400, 0, 0, 0));
      rows.push_back(mk(0, 0, 0, 0, 0, 0));
      foreach (rows[i]) send_request(rows[i].s, rows[i].typed, rows[i].has_report, rows[i].r);
      drain();

      random_phase(200, 0, 0);
      write_csr(atlm_pkg::CSR_LEVEL_THRESHOLD, 0);
      write_csr(atlm_pkg::CSR_SIGNIFICANCE_THRESHOLD, 0);
      write_csr(CSR_SPARE_LOW, 32767);
      write_csr(CSR_SPARE_HIGH, 1);
      random_phase(200, 58, 0);
      write_csr(atlm_pkg::CSR_LEVEL_THRESHOLD, 23040);
      write_csr(atlm_pkg::CSR_SIGNIFICANCE_THRESHOLD, 23040);
      random_phase(150, 0, 58);
      write_csr(atlm_pkg::CSR_LEVEL_THRESHOLD, 32767);
      write_csr(atlm_pkg::CSR_SIGNIFICANCE_THRESHOLD, 32767);
      random_phase(50, 0, 0);
      write_csr(atlm_pkg::CSR_LEVEL_THRESHOLD, 1280);
      write_csr(atlm_pkg::CSR_SIGNIFICANCE_THRESHOLD, 64);
      random_phase(200, 37, 37);

      // long receiver hold-off while requests keep coming, then a full pause
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 4000;
      for (int i = 0; i < 60; i++) send_request(random_sample(), 0, 0, none);
      req.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      for (int i = 0; i < 140; i++) send_request(random_sample(), 0, 0, none);
      drain();

      $display("covered %0d requests, %0d reports, threshold extremes and stall phases",
               requests_sent, reports_seen);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
